@@ rtl/u8v_pkg.sv @@
// Shared types and constants for the UTF-8 text validator.
// No dependencies; used by every module under rtl.
package u8v_pkg;

    localparam int BYTE_W    = 8;
    localparam int PEND_W    = 2;
    localparam int OUT_TDATA_W = 8;

    localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_VALUE  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_VALUE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_VALUE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_VALUE = 8'hF0;

    localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
    localparam logic [PEND_W-1:0] PEND_LEAD2 = 2'd1;
    localparam logic [PEND_W-1:0] PEND_LEAD3 = 2'd2;
    localparam logic [PEND_W-1:0] PEND_LEAD4 = 2'd3;

    typedef enum logic [2:0] {
        CLS_ZERO,
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_BAD
    } byte_class_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] text_byte;
        logic              final_byte;
    } beat_t;

endpackage

@@ rtl/u8v_in_stage.sv @@
// Input register stage of the UTF-8 text validator.
// Depends on u8v_pkg.
module u8v_in_stage (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [u8v_pkg::BYTE_W-1:0] s_tdata,   // [7:0] text_byte
    input  logic                     s_tlast,     // final_byte
    input  logic                     advance,
    output u8v_pkg::beat_t           beat
);

    logic                       valid_reg, valid_next;
    logic [u8v_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                       last_reg, last_next;
    logic                       take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (take) begin
            valid_next = 1'b1;
            byte_next  = s_tdata;
            last_next  = s_tlast;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign beat.valid      = valid_reg;
    assign beat.text_byte  = byte_reg;
    assign beat.final_byte = last_reg;

endmodule

@@ rtl/u8v_decode.sv @@
// Byte classifier of the UTF-8 text validator.
// Depends on u8v_pkg.
module u8v_decode (
    input  logic [u8v_pkg::BYTE_W-1:0] text_byte,
    output u8v_pkg::byte_class_t       byte_class
);

    always_comb begin
        if (text_byte == '0) begin
            byte_class = u8v_pkg::CLS_ZERO;
        end else if (text_byte < u8v_pkg::ASCII_LIMIT) begin
            byte_class = u8v_pkg::CLS_ASCII;
        end else if ((text_byte & u8v_pkg::CONT_MASK) == u8v_pkg::CONT_VALUE) begin
            byte_class = u8v_pkg::CLS_CONT;
        end else if ((text_byte & u8v_pkg::LEAD2_MASK) == u8v_pkg::LEAD2_VALUE) begin
            byte_class = u8v_pkg::CLS_LEAD2;
        end else if ((text_byte & u8v_pkg::LEAD3_MASK) == u8v_pkg::LEAD3_VALUE) begin
            byte_class = u8v_pkg::CLS_LEAD3;
        end else if ((text_byte & u8v_pkg::LEAD4_MASK) == u8v_pkg::LEAD4_VALUE) begin
            byte_class = u8v_pkg::CLS_LEAD4;
        end else begin
            byte_class = u8v_pkg::CLS_BAD;
        end
    end

endmodule

@@ rtl/u8v_seq.sv @@
// Sequence tracker and result register of the UTF-8 text validator.
// Depends on u8v_pkg.
module u8v_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  u8v_pkg::beat_t                beat,
    input  u8v_pkg::byte_class_t          byte_class,
    output logic                          advance,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [u8v_pkg::OUT_TDATA_W-1:0] m_tdata   // [0] text_valid
);

    logic [u8v_pkg::PEND_W-1:0] pend_reg, pend_next;
    logic [u8v_pkg::PEND_W-1:0] pend_upd;
    logic                       err_reg, err_next, err_upd;
    logic                       out_valid_reg, out_valid_next;
    logic                       result_reg, result_next;
    logic                       out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = beat.valid && (!beat.final_byte || out_free);

    always_comb begin
        pend_upd = pend_reg;
        err_upd  = err_reg;
        if (pend_reg != u8v_pkg::PEND_NONE) begin
            if (byte_class == u8v_pkg::CLS_CONT) begin
                pend_upd = pend_reg - 1'b1;
            end else begin
                err_upd = 1'b1;
            end
        end else begin
            unique case (byte_class)
                u8v_pkg::CLS_ASCII: ;
                u8v_pkg::CLS_LEAD2: pend_upd = u8v_pkg::PEND_LEAD2;
                u8v_pkg::CLS_LEAD3: pend_upd = u8v_pkg::PEND_LEAD3;
                u8v_pkg::CLS_LEAD4: pend_upd = u8v_pkg::PEND_LEAD4;
                default:            err_upd  = 1'b1;
            endcase
        end
    end

    always_comb begin
        pend_next      = pend_reg;
        err_next       = err_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (advance) begin
            if (beat.final_byte) begin
                pend_next      = u8v_pkg::PEND_NONE;
                err_next       = 1'b0;
                out_valid_next = 1'b1;
                result_next    = !err_upd && (pend_upd == u8v_pkg::PEND_NONE);
            end else begin
                pend_next = pend_upd;
                err_next  = err_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= u8v_pkg::PEND_NONE;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_reg      <= pend_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
        result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(u8v_pkg::OUT_TDATA_W-1){1'b0}}, result_reg};

endmodule

@@ rtl/utf8_text_validator.sv @@
// UTF-8 text validator, top level: input register, byte classifier, sequence tracker.
// Depends on u8v_pkg, u8v_in_stage, u8v_decode and u8v_seq.
//
// Checks a buffer streamed one byte per transfer, final byte marked by s_tlast, and
// returns one result per buffer on m_tdata[0]: 1 when the buffer is well-formed UTF-8
// with no zero byte. Overlong forms, surrogates and code points above U+10FFFF pass.
// Bytes are accepted at one per clock unless a final byte waits on the output register.
// A final byte passes the input register and its result is registered in the output
// register; a waiting result stalls only the next final byte, other bytes keep flowing.
module utf8_text_validator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [u8v_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] text_byte
    input  logic                            s_tlast,   // final_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [u8v_pkg::OUT_TDATA_W-1:0] m_tdata    // [0] text_valid, [7:1] zero
);

    u8v_pkg::beat_t       beat;
    u8v_pkg::byte_class_t byte_class;
    logic                 advance;

    u8v_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .advance  (advance),
        .beat     (beat)
    );

    u8v_decode u_dec (
        .text_byte  (beat.text_byte),
        .byte_class (byte_class)
    );

    u8v_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat       (beat),
        .byte_class (byte_class),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

@@ rtl/u8v_props.sv @@
// Port-level checks for the UTF-8 text validator, bound to its top level.
// Depends on u8v_pkg and utf8_text_validator.
module u8v_props (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [u8v_pkg::BYTE_W-1:0]      s_tdata,
    input logic                            s_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [u8v_pkg::OUT_TDATA_W-1:0] m_tdata
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result transfer changed");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[u8v_pkg::OUT_TDATA_W-1:1] == '0)
        else $error("result padding not zero");

    a_stall_only_on_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    a_in_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid |-> !$isunknown({s_tdata, s_tlast}))
        else $error("input transfer carries unknown bits");

endmodule

bind utf8_text_validator u8v_props u_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
